[hw/rtl/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds now, consequent holds on the next edge
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

// antecedent and consequent on the same edge
`define ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

`endif

[hw/rtl/spr_pkg.sv]
`default_nettype none

package spr_pkg;

  localparam int POSITION_WIDTH_DEF = 32;
  localparam int CFG_INDEX_WIDTH    = 3;

  localparam logic [31:0] RAMP_START_COUNT_RESET  = 32'd0;
  localparam logic [31:0] RAMP_STOP_COUNT_RESET   = 32'd0;
  localparam logic [31:0] RAMP_INTERVAL_RESET     = 32'd1;
  localparam logic [31:0] RAMP_INITIAL_RATE_RESET = 32'd0;
  localparam logic [31:0] RAMP_FINAL_RATE_RESET   = 32'd0;

  typedef enum logic [1:0] {
    FUNC_MOVE  = 2'd0,
    FUNC_PULSE = 2'd1,
    FUNC_HOME  = 2'd2
  } func_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_RAMP_START_COUNT  = 3'd0,
    REG_RAMP_STOP_COUNT   = 3'd1,
    REG_RAMP_INTERVAL     = 3'd2,
    REG_RAMP_INITIAL_RATE = 3'd3,
    REG_RAMP_FINAL_RATE   = 3'd4
  } reg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MOD,
    S_MUL,
    S_DIVST,
    S_DIV,
    S_ARRIVE,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] target;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic               direction;
    logic               moving;
    logic               counting;
    logic               drive_enabled;
    logic [31:0]        step_rate;
    logic               rate_changed;
    logic               on_ramp;
    logic               arrived;
  } out_item_t;

  typedef struct packed {
    logic [31:0] ramp_start_count;
    logic [31:0] ramp_stop_count;
    logic [31:0] ramp_interval;
    logic [31:0] ramp_initial_rate;
    logic [31:0] ramp_final_rate;
  } cfg_t;

  // divider request: remainder preload must stay below the divisor
  typedef struct packed {
    logic        start;
    logic [31:0] rem_init;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_ctrl_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quotient;
    logic [31:0] remainder;
  } div_stat_t;

endpackage

`default_nettype wire

[hw/rtl/spr_divider.sv]
`default_nettype none

module spr_divider
  import spr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire div_ctrl_t ctrl,
  output div_stat_t      stat
);

  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic [4:0]  cnt;
  logic        busy;
  logic        done;

  logic [32:0] trial;
  logic [32:0] diff;

  // one restoring step per cycle, quotient bits shift in behind the dividend
  assign trial = {rem, quo[31]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem <= ctrl.rem_init;
      quo <= ctrl.dividend;
      dvs <= ctrl.divisor;
    end else if (busy) begin
      if (!diff[32]) begin
        rem <= diff[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  assign stat.busy      = busy;
  assign stat.done      = done;
  assign stat.quotient  = quo;
  assign stat.remainder = rem;

endmodule

`default_nettype wire

[hw/rtl/spr_core.sv]
`default_nettype none

module spr_core
  import spr_pkg::*;
#(
  parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data,
  input  wire cfg_t      cfg,
  output div_ctrl_t      div_ctrl,
  input  wire div_stat_t div_stat
);

  localparam int PW = POSITION_WIDTH;

  state_t          state, state_next;
  in_item_t        item, item_next;
  logic [PW-1:0]   position_reg, position_reg_next;
  logic [PW-1:0]   target_reg, target_reg_next;
  logic [31:0]     pulse_count, pulse_count_next;
  logic            dir_reg, dir_reg_next;
  logic            moving_reg, moving_reg_next;
  logic            counting_reg, counting_reg_next;
  logic            enable_reg, enable_reg_next;
  logic [31:0]     rate_reg, rate_reg_next;
  logic            ramp_flag, ramp_flag_next;
  logic            changed, changed_next;
  logic            arrived, arrived_next;
  logic [31:0]     off, off_next;
  logic [31:0]     d_mag, d_mag_next;
  logic            d_neg, d_neg_next;
  logic [63:0]     prod, prod_next;
  logic            out_valid_next;
  out_item_t       out_data_next;

  logic [31:0]        count_inc;
  logic [31:0]        off_calc;
  logic               in_window;
  logic [31:0]        delta;
  logic signed [63:0] target_wide;
  logic [PW-1:0]      target_new;
  logic [PW-1:0]      move_diff;
  logic [63:0]        position_wide;
  logic [31:0]        update_end;

  assign count_inc     = pulse_count + 32'd1;
  assign off_calc      = count_inc - cfg.ramp_start_count;
  assign in_window     = (count_inc > cfg.ramp_start_count) &&
                         (count_inc < cfg.ramp_stop_count);
  assign delta         = cfg.ramp_final_rate - cfg.ramp_initial_rate;
  assign target_wide   = 64'(item.target);
  assign target_new    = PW'(target_wide);
  assign move_diff     = target_new - position_reg;
  assign position_wide = 64'(position_reg);
  assign update_end    = pulse_count + cfg.ramp_interval;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      position_reg <= '0;
      target_reg   <= '0;
      pulse_count  <= '0;
      dir_reg      <= 1'b0;
      moving_reg   <= 1'b0;
      counting_reg <= 1'b0;
      enable_reg   <= 1'b0;
      rate_reg     <= RAMP_INITIAL_RATE_RESET;
      ramp_flag    <= 1'b0;
      changed      <= 1'b0;
      arrived      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      position_reg <= position_reg_next;
      target_reg   <= target_reg_next;
      pulse_count  <= pulse_count_next;
      dir_reg      <= dir_reg_next;
      moving_reg   <= moving_reg_next;
      counting_reg <= counting_reg_next;
      enable_reg   <= enable_reg_next;
      rate_reg     <= rate_reg_next;
      ramp_flag    <= ramp_flag_next;
      changed      <= changed_next;
      arrived      <= arrived_next;
      out_valid    <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    item     <= item_next;
    off      <= off_next;
    d_mag    <= d_mag_next;
    d_neg    <= d_neg_next;
    prod     <= prod_next;
    out_data <= out_data_next;
  end

  always_comb begin
    state_next        = state;
    item_next         = item;
    position_reg_next = position_reg;
    target_reg_next   = target_reg;
    pulse_count_next  = pulse_count;
    dir_reg_next      = dir_reg;
    moving_reg_next   = moving_reg;
    counting_reg_next = counting_reg;
    enable_reg_next   = enable_reg;
    rate_reg_next     = rate_reg;
    ramp_flag_next    = ramp_flag;
    changed_next      = changed;
    arrived_next      = arrived;
    off_next          = off;
    d_mag_next        = d_mag;
    d_neg_next        = d_neg;
    prod_next         = prod;
    out_valid_next    = out_valid && out_stall;
    out_data_next     = out_data;
    div_ctrl          = '0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          item_next  = in_data;
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        changed_next = 1'b0;
        arrived_next = 1'b0;
        d_neg_next   = delta[31];
        d_mag_next   = delta[31] ? (32'd0 - delta) : delta;
        state_next   = S_OUT;
        case (item.func)
          FUNC_MOVE: begin
            target_reg_next = target_new;
            dir_reg_next    = move_diff[PW-1];
            if (move_diff != '0) begin
              counting_reg_next = 1'b1;
              moving_reg_next   = 1'b1;
              enable_reg_next   = 1'b1;
            end
          end
          FUNC_PULSE: begin
            if (counting_reg) begin
              pulse_count_next = count_inc;
              off_next         = off_calc;
              if (moving_reg) begin
                position_reg_next = dir_reg ? (position_reg - PW'(1))
                                            : (position_reg + PW'(1));
              end
              ramp_flag_next = in_window;
              state_next     = S_ARRIVE;
              if (in_window && (cfg.ramp_interval != 32'd0)) begin
                // remainder of the ramp offset by the interval
                div_ctrl.start    = 1'b1;
                div_ctrl.rem_init = 32'd0;
                div_ctrl.dividend = off_calc;
                div_ctrl.divisor  = cfg.ramp_interval;
                state_next        = S_MOD;
              end
            end
          end
          FUNC_HOME: begin
            position_reg_next = '0;
            moving_reg_next   = 1'b0;
            enable_reg_next   = 1'b0;
          end
          default: begin
          end
        endcase
      end

      S_MOD: begin
        if (div_stat.done) begin
          state_next = S_ARRIVE;
          if (div_stat.remainder == 32'd0) begin
            changed_next = 1'b1;
            if (update_end >= cfg.ramp_stop_count) begin
              rate_reg_next = cfg.ramp_final_rate;
            end else begin
              state_next = S_MUL;
            end
          end
        end
      end

      S_MUL: begin
        prod_next  = 64'(d_mag) * 64'(off);
        state_next = S_DIVST;
      end

      S_DIVST: begin
        // offset is below the span, so the quotient fits in 32 bits
        div_ctrl.start    = 1'b1;
        div_ctrl.rem_init = prod[63:32];
        div_ctrl.dividend = prod[31:0];
        div_ctrl.divisor  = cfg.ramp_stop_count - cfg.ramp_start_count;
        state_next        = S_DIV;
      end

      S_DIV: begin
        if (div_stat.done) begin
          rate_reg_next = cfg.ramp_initial_rate +
                          (d_neg ? (32'd0 - div_stat.quotient) : div_stat.quotient);
          state_next    = S_ARRIVE;
        end
      end

      S_ARRIVE: begin
        if (target_reg == position_reg) begin
          counting_reg_next = 1'b0;
          pulse_count_next  = '0;
          moving_reg_next   = 1'b0;
          arrived_next      = 1'b1;
        end
        state_next = S_OUT;
      end

      S_OUT: begin
        if (!out_valid || !out_stall) begin
          out_valid_next              = 1'b1;
          out_data_next.position      = position_wide[31:0];
          out_data_next.direction     = dir_reg;
          out_data_next.moving        = moving_reg;
          out_data_next.counting      = counting_reg;
          out_data_next.drive_enabled = enable_reg;
          out_data_next.step_rate     = rate_reg;
          out_data_next.rate_changed  = changed;
          out_data_next.on_ramp       = ramp_flag;
          out_data_next.arrived       = arrived;
          state_next                  = S_IDLE;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/stepper_position_with_linear_ramp.sv]
// stepper move controller with a linear step-rate ramp
// input channel (in_valid / in_stall / in_data): one item per command, func selects
//   move to target, step pulse edge or home switch reached
// output channel (out_valid / out_stall / out_data): exactly one result item per
//   input item, in order, showing the position, flags and step rate after it
// config port (cfg_write / cfg_index / cfg_data): writes the five ramp registers;
//   the user must write them only while no item is in flight, which the block
//   leaves unchecked; indexes past the last register are dropped
// steps: move, home, unused codes and uncounted pulses pass S_EXEC and S_OUT;
//   counted pulses outside the ramp window also pass S_ARRIVE; a pulse inside
//   the window with a nonzero interval runs the shared 32-step serial divider
//   for the interval remainder and again for the slope of an interpolated rate
// throughput: one item at a time, in_stall is high from accept until the result
//   is loaded into the output register; the next item can enter while that
//   result still waits
// stall: a stalled result holds in the output register; a finished item waits
//   in its last step until the register frees up
// reset: synchronous, clears position, target, count and flags, empties the output
//   register, and loads the ramp registers and the rate with their defaults
`default_nettype none

module stepper_position_with_linear_ramp
  import spr_pkg::*;
#(
  parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire in_item_t                   in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output out_item_t                       out_data,
  input  wire logic                       cfg_write,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [31:0]                cfg_data
);

  cfg_t      cfg;
  div_ctrl_t div_ctrl;
  div_stat_t div_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ramp_start_count  <= RAMP_START_COUNT_RESET;
      cfg.ramp_stop_count   <= RAMP_STOP_COUNT_RESET;
      cfg.ramp_interval     <= RAMP_INTERVAL_RESET;
      cfg.ramp_initial_rate <= RAMP_INITIAL_RATE_RESET;
      cfg.ramp_final_rate   <= RAMP_FINAL_RATE_RESET;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_RAMP_START_COUNT:  cfg.ramp_start_count  <= cfg_data;
        REG_RAMP_STOP_COUNT:   cfg.ramp_stop_count   <= cfg_data;
        REG_RAMP_INTERVAL:     cfg.ramp_interval     <= cfg_data;
        REG_RAMP_INITIAL_RATE: cfg.ramp_initial_rate <= cfg_data;
        REG_RAMP_FINAL_RATE:   cfg.ramp_final_rate   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  spr_core #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg      (cfg),
    .div_ctrl (div_ctrl),
    .div_stat (div_stat)
  );

  spr_divider u_div (
    .clk (clk),
    .rst (rst),
    .ctrl(div_ctrl),
    .stat(div_stat)
  );

endmodule

`default_nettype wire

[hw/rtl/spr_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module spr_checker
  import spr_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire out_item_t out_data,
  input wire logic      out_valid,
  input wire logic      out_stall
);

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))

  // the block is busy right after it takes an item
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)

  // reset empties the output register
  `ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !out_valid)

  // arrival ends motion and counting
  `ASSERT_NOW(a_arrive_stops, clk, rst, out_valid && out_data.arrived,
              !out_data.moving && !out_data.counting)

endmodule

bind stepper_position_with_linear_ramp spr_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_data (out_data),
  .out_valid(out_valid),
  .out_stall(out_stall)
);

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import spr_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int N_SETTINGS = 10;
  localparam int ITEMS_PER_SETTING = 40;
  localparam int HOLD_AFTER = 260;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT = 3000;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  stepper_position_with_linear_ramp u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // shadow of the ramp registers and the controller state
  cfg_t ramp_cfg = '{RAMP_START_COUNT_RESET, RAMP_STOP_COUNT_RESET, RAMP_INTERVAL_RESET,
                     RAMP_INITIAL_RATE_RESET, RAMP_FINAL_RATE_RESET};
  logic [31:0] pos_q = '0;
  logic [31:0] tgt_q = '0;
  logic [31:0] pulses_q = '0;
  logic [31:0] rate_q = RAMP_INITIAL_RATE_RESET;
  logic dir_q = 1'b0;
  logic moving_q = 1'b0;
  logic counting_q = 1'b0;
  logic enable_q = 1'b0;
  logic ramp_q = 1'b0;

  in_item_t motor_cmds[$];
  out_item_t expected_reports[$];

  int in_count = 0;
  int n_results = 0;
  int n_errors = 0;
  int n_rate_updates = 0;
  int n_arrivals = 0;
  int src_gap = 0;
  int sink_wait = 0;
  bit src_calm = 1'b0;
  bit sink_calm = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int hold_left = 0;
  int idle_cycles = 0;
  logic [31:0] gen_pos = '0;
  bit gen_known = 1'b0;
  out_item_t got_report;
  out_item_t want_report;

  function automatic out_item_t advance_motor(in_item_t cmd);
    logic [31:0] diff, off, span, delta_u, next_count;
    longint slope, scaled;
    logic wrote, reached;
    out_item_t r;
    wrote = 1'b0;
    reached = 1'b0;
    case (cmd.func)
      FUNC_MOVE: begin
        tgt_q = cmd.target;
        diff = tgt_q - pos_q;
        dir_q = diff[31];
        if (diff != 0) begin
          counting_q = 1'b1;
          moving_q = 1'b1;
          enable_q = 1'b1;
        end
      end
      FUNC_PULSE: begin
        if (counting_q) begin
          pulses_q = pulses_q + 1;
          if (moving_q) pos_q = dir_q ? pos_q - 1 : pos_q + 1;
          if (pulses_q > ramp_cfg.ramp_start_count && pulses_q < ramp_cfg.ramp_stop_count) begin
            ramp_q = 1'b1;
            off = pulses_q - ramp_cfg.ramp_start_count;
            if (ramp_cfg.ramp_interval != 0 && off % ramp_cfg.ramp_interval == 0) begin
              next_count = pulses_q + ramp_cfg.ramp_interval;
              if (next_count >= ramp_cfg.ramp_stop_count) begin
                rate_q = ramp_cfg.ramp_final_rate;
              end else begin
                // signed rate delta times offset over window length, toward zero
                delta_u = ramp_cfg.ramp_final_rate - ramp_cfg.ramp_initial_rate;
                span = ramp_cfg.ramp_stop_count - ramp_cfg.ramp_start_count;
                slope = $signed(delta_u);
                scaled = slope * longint'({32'h0, off}) / longint'({32'h0, span});
                rate_q = ramp_cfg.ramp_initial_rate + scaled[31:0];
              end
              wrote = 1'b1;
              n_rate_updates++;
            end
          end else begin
            ramp_q = 1'b0;
          end
          if (tgt_q == pos_q) begin
            counting_q = 1'b0;
            pulses_q = '0;
            moving_q = 1'b0;
            reached = 1'b1;
            n_arrivals++;
          end
        end
      end
      FUNC_HOME: begin
        pos_q = '0;
        moving_q = 1'b0;
        enable_q = 1'b0;
      end
      default: begin
      end
    endcase
    r.position = pos_q;
    r.direction = dir_q;
    r.moving = moving_q;
    r.counting = counting_q;
    r.drive_enabled = enable_q;
    r.step_rate = rate_q;
    r.rate_changed = wrote;
    r.on_ramp = ramp_q;
    r.arrived = reached;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    n_errors++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s is %h, expected %h", n_results, name, got, want));
  endtask

  task automatic queue_cmd(logic [1:0] f, logic [31:0] t);
    in_item_t it;
    it.func = f;
    it.target = t;
    motor_cmds.push_back(it);
  endtask

  task automatic write_reg(reg_index_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  task automatic program_ramp(cfg_t c);
    write_reg(REG_RAMP_START_COUNT, c.ramp_start_count);
    write_reg(REG_RAMP_STOP_COUNT, c.ramp_stop_count);
    write_reg(REG_RAMP_INTERVAL, c.ramp_interval);
    write_reg(REG_RAMP_INITIAL_RATE, c.ramp_initial_rate);
    write_reg(REG_RAMP_FINAL_RATE, c.ramp_final_rate);
    @(posedge clk);
    cfg_write <= 1'b0;
    ramp_cfg = c;
  endtask

  function automatic cfg_t ramp_setting(int p);
    cfg_t c;
    case (p)
      0: c = '{32'd2, 32'd20, 32'd1, 32'd100, 32'd500};
      1: c = '{32'd0, 32'd12, 32'd3, 32'd1000, 32'd10};
      2: c = '{32'd1, 32'd30, 32'd0, 32'd7, 32'd9};
      3: c = '{32'd10, 32'd11, 32'd2, 32'd5, 32'd6};
      4: c = '{32'd0, 32'd8, 32'd2, 32'd0, 32'h7fff_ffff};
      5: c = '{32'd0, 32'd25, 32'd4, 32'h8000_0000, 32'd0};
      6: c = '{32'd0, 32'hffff_ffff, 32'd5, 32'd0, 32'hffff_ffff};
      7: c = '{32'hffff_ffff, 32'd0, 32'hffff_ffff, 32'hffff_ffff, 32'd0};
      default: begin
        c.ramp_start_count = $urandom_range(0, 10);
        c.ramp_stop_count = c.ramp_start_count + $urandom_range(0, 35);
        c.ramp_interval = $urandom_range(0, 6);
        c.ramp_initial_rate = $urandom();
        c.ramp_final_rate = $urandom();
      end
    endcase
    return c;
  endfunction

  task automatic queue_directed();
    queue_cmd(FUNC_PULSE, 32'd0);           // pulse with counting off
    queue_cmd(FUNC_UNUSED, 32'h5555_5555);
    queue_cmd(FUNC_MOVE, 32'd0);            // target equals position
    queue_cmd(FUNC_MOVE, 32'hffff_ffff);
    queue_cmd(FUNC_PULSE, 32'd0);           // wraps below zero and arrives
    queue_cmd(FUNC_MOVE, 32'h7fff_ffff);
    queue_cmd(FUNC_PULSE, 32'd0);
    queue_cmd(FUNC_MOVE, 32'h8000_0000);
    queue_cmd(FUNC_PULSE, 32'd0);
    queue_cmd(FUNC_HOME, 32'd0);            // counting stays on
    queue_cmd(FUNC_PULSE, 32'd0);           // counts, position holds
    queue_cmd(FUNC_PULSE, 32'd0);
    queue_cmd(FUNC_MOVE, 32'd0);
    queue_cmd(FUNC_PULSE, 32'd0);           // arrives without moving
    queue_cmd(FUNC_PULSE, 32'd0);
    queue_cmd(FUNC_MOVE, 32'd2);
    queue_cmd(FUNC_PULSE, 32'd0);
    queue_cmd(FUNC_PULSE, 32'd0);
    queue_cmd(FUNC_HOME, 32'hffff_ffff);
    queue_cmd(FUNC_MOVE, 32'hffff_fffe);
    queue_cmd(FUNC_UNUSED, 32'hffff_ffff);
    queue_cmd(FUNC_PULSE, 32'd0);
    queue_cmd(FUNC_PULSE, 32'd0);
  endtask

  // mostly complete moves that run to arrival, some cut short, some noise
  task automatic queue_random_moves(int n);
    int added, step, sel;
    logic [31:0] t;
    added = 0;
    while (added < n) begin
      sel = $urandom_range(0, 9);
      if (sel < 8) begin
        if (!gen_known || $urandom_range(0, 4) == 0) begin
          queue_cmd(FUNC_HOME, $urandom());
          gen_pos = '0;
          gen_known = 1'b1;
          added++;
        end
        step = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 40);
        t = $urandom_range(0, 1) ? gen_pos + step : gen_pos - step;
        queue_cmd(FUNC_MOVE, t);
        if (sel == 7) begin
          repeat ($urandom_range(0, step)) queue_cmd(FUNC_PULSE, $urandom());
          gen_known = 1'b0;
        end else begin
          repeat (step + $urandom_range(0, 1)) queue_cmd(FUNC_PULSE, $urandom());
          gen_pos = t;
        end
        added += 1 + step;
      end else begin
        queue_cmd(2'($urandom_range(0, 3)), $urandom());
        gen_known = 1'b0;
        added++;
      end
    end
  endtask

  task automatic drain();
    while (motor_cmds.size() != 0 || in_valid || expected_reports.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
      src_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_reports.push_back(advance_motor(in_data));
        in_count <= in_count + 1;
        if (!hold_req && in_count >= HOLD_AFTER && motor_cmds.size() > 20) hold_req <= 1'b1;
      end
      if (in_valid && in_stall) begin
        // stalled item stays put
      end else if (src_gap != 0) begin
        in_valid <= 1'b0;
        src_gap--;
      end else if (motor_cmds.size() != 0) begin
        in_data <= motor_cmds.pop_front();
        in_valid <= 1'b1;
        src_gap = src_calm ? 0 : $urandom_range(0, 8);
        if ($urandom_range(0, 31) == 0) src_calm = !src_calm;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // one long receiver hold-off while items keep coming
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      sink_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got_report = out_data;
        if (expected_reports.size() == 0) begin
          report_mismatch($sformatf("result %0d came with no item outstanding", n_results));
        end else begin
          want_report = expected_reports.pop_front();
          check_field("position", got_report.position, want_report.position);
          check_field("direction", got_report.direction, want_report.direction);
          check_field("moving", got_report.moving, want_report.moving);
          check_field("counting", got_report.counting, want_report.counting);
          check_field("drive_enabled", got_report.drive_enabled, want_report.drive_enabled);
          check_field("step_rate", got_report.step_rate, want_report.step_rate);
          check_field("rate_changed", got_report.rate_changed, want_report.rate_changed);
          check_field("on_ramp", got_report.on_ramp, want_report.on_ramp);
          check_field("arrived", got_report.arrived, want_report.arrived);
        end
        n_results++;
        sink_wait = sink_calm ? 0 : $urandom_range(0, 8);
        if ($urandom_range(0, 31) == 0) sink_calm = !sink_calm;
      end else if (sink_wait != 0) begin
        sink_wait--;
      end
      out_stall <= (hold_left != 0) || (sink_wait != 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("no handshake for %0d cycles", IDLE_LIMIT);
      $display("testbench: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    queue_directed();
    drain();
    for (int p = 0; p < N_SETTINGS; p++) begin
      program_ramp(ramp_setting(p));
      @(negedge clk);
      queue_random_moves(ITEMS_PER_SETTING);
      drain();
    end
    repeat (100) @(negedge clk);
    $display("ran %0d items, %0d results checked, over %0d ramp settings",
             in_count, n_results, N_SETTINGS);
    $display("%0d step-rate updates, %0d arrivals, %0d mismatches",
             n_rate_updates, n_arrivals, n_errors);
    if (n_errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
